// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; the including module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// File: rtl/stc_pkg.sv
// Types, constants and helper functions for the scratchpad temperature check.
// No dependencies.
`default_nettype none

package stc_pkg;

  localparam int unsigned POS_W    = 4;
  localparam logic [7:0]  CRC_POLY = 8'h8C;
  localparam logic [3:0]  RES_MIN  = 4'd9;
  localparam logic [3:0]  RES_MAX  = 4'd12;
  localparam logic [3:0]  RES_INIT = 4'd12;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temperature_sixteenths;
    logic               crc_ok;
  } out_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Mask of kept temperature bits for a given resolution setting.
  function automatic logic [15:0] res_mask(input logic [3:0] res);
    logic [1:0] drop;
    if (res < RES_MIN) begin
      drop = 2'd3;
    end else if (res > RES_MAX) begin
      drop = 2'd0;
    end else begin
      drop = 2'(RES_MAX - res);
    end
    return {13'h1FFF, 3'b111 << drop};
  endfunction

endpackage

`default_nettype wire

// File: rtl/stc_frame.sv
// Frame tracker: byte position, running CRC-8, temperature bytes, resolution register.
// Depends on stc_pkg.
`default_nettype none

module stc_frame #(
  parameter int unsigned FRAME_BYTES = 9
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [3:0]    cfg_wdata,
  input  wire logic          acc,
  input  wire stc_pkg::in_t  item,
  output logic               res_valid,
  output stc_pkg::out_t      res_data
);
  import stc_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_cur;
  logic [7:0]       crc_r, crc_nxt, crc_cur;
  logic [7:0]       lo_r, lo_nxt, hi_r, hi_nxt;
  logic [3:0]       res_r;
  logic             last;
  logic [15:0]      raw;
  logic             ok;

  always_comb begin
    pos_cur   = item.frame_start ? '0 : pos_r;
    crc_cur   = (pos_cur == '0) ? 8'h00 : crc_r;
    last      = (pos_cur >= LAST_POS);
    raw       = {hi_r, lo_r} & res_mask(res_r);
    ok        = (crc_cur == item.data_byte);
    res_valid = acc && last;
    res_data.crc_ok                 = ok;
    res_data.temperature_sixteenths = ok ? raw : 16'sd0;
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    if (acc) begin
      if (last) begin
        pos_nxt = '0;
        crc_nxt = crc_cur;
      end else begin
        pos_nxt = pos_cur + 1'b1;
        crc_nxt = crc8_byte(crc_cur, item.data_byte);
        if (pos_cur == POS_W'(0)) begin
          lo_nxt = item.data_byte;
        end
        if (pos_cur == POS_W'(1)) begin
          hi_nxt = item.data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= '0;
      lo_r  <= '0;
      hi_r  <= '0;
      res_r <= RES_INIT;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      if (cfg_we) begin
        res_r <= cfg_wdata;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/stc_outbuf.sv
// Result register with skid entry; decouples input acceptance from output stall.
// Depends on stc_pkg.
`default_nettype none

module stc_outbuf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire stc_pkg::out_t push_data,
  output logic               full,
  output logic               out_valid,
  input  wire logic          out_stall,
  output stc_pkg::out_t      out_data
);
  import stc_pkg::*;

  logic main_v_r, main_v_nxt, skid_v_r, skid_v_nxt;
  out_t main_r, main_nxt, skid_r, skid_nxt;
  logic pop;

  always_comb begin
    pop        = main_v_r && !out_stall;
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else if (push) begin
        main_nxt = push_data;
      end else begin
        main_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r) begin
        main_nxt   = push_data;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_data;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

endmodule

`default_nettype wire

// File: rtl/scratchpad_temperature_check_unit.sv
// Scratchpad temperature check: CRC-8 over a sensor scratchpad frame, temperature decode.
// Depends on stc_pkg, stc_frame, stc_outbuf and assert_macros.svh.
//
//   channel  | direction | handshake           | payload
//   in       | input     | in_valid/in_stall   | stc_pkg::in_t (data_byte, frame_start)
//   out      | output    | out_valid/out_stall | stc_pkg::out_t (temperature, crc_ok)
//   cfg      | input     | cfg_we              | cfg_wdata (resolution_bits)
//
// One byte per cycle while in_stall is low; the CRC-8 update for a byte is one combinational pass.
// A result is registered into the result register, or its skid entry, when its last byte is taken.
// Synchronous active-low reset; resolution resets to 12 bits.
// in_stall rises only while both the result register and its skid entry are full.
`default_nettype none

module scratchpad_temperature_check_unit #(
  parameter int unsigned FRAME_BYTES = 9
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [3:0]    cfg_wdata,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire stc_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output stc_pkg::out_t      out_data
);
  import stc_pkg::*;

  `include "assert_macros.svh"

  logic acc;
  logic res_valid;
  out_t res_data;
  logic full;
  logic out_held;
  logic bad_crc_temp;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  stc_frame #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .item      (in_data),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  stc_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res_data),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_held     = out_valid && out_stall;
  assign bad_crc_temp = out_valid && !out_data.crc_ok &&
                        (out_data.temperature_sixteenths != 16'sd0);

  `ASSERT_IMPLY(a_stall_needs_result, in_stall, out_valid, "input stalled with no result")
  `ASSERT_IMPLY(a_stall_after_block, in_stall, $past(out_held), "stall without output stall")
  `ASSERT_NEVER(a_bad_crc_zero, bad_crc_temp, "temperature not zero on crc error")

endmodule

`default_nettype wire

// File: verif/temp_frame_check.sv
// CRC helper for the stimulus and a passive checker for scratchpad_temperature_check_unit.
// Needs stc_pkg; watches the cfg, in and out channels, predicts each reading and compares it.
`default_nettype none

package scratchpad_crc_pkg;

  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ d[0];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ stc_pkg::CRC_POLY;
      end
      d = d >> 1;
    end
    return acc;
  endfunction

endpackage

module temp_frame_check #(
  parameter int unsigned FRAME_BYTES = 9
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [3:0]    cfg_wdata,
  input  wire logic          in_valid,
  input  wire logic          in_stall,
  input  wire stc_pkg::in_t  in_data,
  input  wire logic          out_valid,
  input  wire logic          out_stall,
  input  wire stc_pkg::out_t out_data,
  output int                 fail_count,
  output int                 readings_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import scratchpad_crc_pkg::crc8_next;

  stc_pkg::out_t expected_readings[$];
  logic [3:0]    resolution;
  logic [3:0]    position;
  logic [7:0]    crc_acc;
  logic [7:0]    temp_lo;
  logic [7:0]    temp_hi;
  int            fails;

  initial begin
    fails            = 0;
    fail_count       = 0;
    readings_pending = 0;
  end

  always @(posedge clk) begin
    stc_pkg::out_t want;
    stc_pkg::out_t reading;
    logic [3:0]    pos;
    logic [7:0]    crc;
    logic [15:0]   raw;
    int            drop;
    if (!rst_n) begin
      resolution = stc_pkg::RES_INIT;
      position   = '0;
      crc_acc    = '0;
      temp_lo    = '0;
      temp_hi    = '0;
      expected_readings.delete();
    end else begin
      if (cfg_we) begin
        resolution = cfg_wdata;
      end

      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $error("unexpected reading: temperature_sixteenths %0d crc_ok %0b",
                 out_data.temperature_sixteenths, out_data.crc_ok);
          fails++;
        end else begin
          want = expected_readings.pop_front();
          if (out_data.temperature_sixteenths !== want.temperature_sixteenths) begin
            $error("temperature_sixteenths: expected %0d, got %0d",
                   want.temperature_sixteenths, out_data.temperature_sixteenths);
            fails++;
          end
          if (out_data.crc_ok !== want.crc_ok) begin
            $error("crc_ok: expected %0b, got %0b", want.crc_ok, out_data.crc_ok);
            fails++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        pos = in_data.frame_start ? 4'd0 : position;
        crc = (pos == 4'd0) ? 8'h00 : crc_acc;
        if (pos < FRAME_BYTES - 1) begin
          crc_acc = crc8_next(crc, in_data.data_byte);
          if (pos == 4'd0) begin
            temp_lo = in_data.data_byte;
          end else if (pos == 4'd1) begin
            temp_hi = in_data.data_byte;
          end
          position = pos + 4'd1;
        end else begin
          if (resolution < stc_pkg::RES_MIN) begin
            drop = 3;
          end else if (resolution > stc_pkg::RES_MAX) begin
            drop = 0;
          end else begin
            drop = int'(stc_pkg::RES_MAX) - int'(resolution);
          end
          raw = {temp_hi, temp_lo} & ~((16'd1 << drop) - 16'd1);
          reading.crc_ok                 = (crc == in_data.data_byte);
          reading.temperature_sixteenths = reading.crc_ok ? raw : 16'sd0;
          expected_readings.push_back(reading);
          crc_acc  = crc;
          position = '0;
        end
      end
    end
    fail_count       <= fails;
    readings_pending <= expected_readings.size();
  end

endmodule

`default_nettype wire

// File: verif/tb.sv
// Top testbench for scratchpad_temperature_check_unit: clock, reset, stimulus and verdict.
// Needs stc_pkg, the unit's RTL and temp_frame_check (with scratchpad_crc_pkg).
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scratchpad_crc_pkg::crc8_next;

  localparam int unsigned FRAME_LEN = 9;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [3:0]    cfg_wdata;
  logic          in_valid;
  logic          in_stall;
  stc_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  stc_pkg::out_t out_data;
  int            fail_count;
  int            readings_pending;
  int            bytes_sent;
  logic          aligned;

  scratchpad_temperature_check_unit #(
    .FRAME_BYTES(FRAME_LEN)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  temp_frame_check #(
    .FRAME_BYTES(FRAME_LEN)
  ) u_frame_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .readings_pending(readings_pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #400_000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic start, input logic quiet);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid              = 1'b1;
    in_data.data_byte     = b;
    in_data.frame_start   = start;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] lo, input logic [7:0] hi, input logic start,
                            input logic good, input logic quiet);
    logic [7:0] crc;
    logic [7:0] b;
    crc = 8'h00;
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      b   = (i == 0) ? lo : (i == 1) ? hi : 8'($urandom_range(0, 255));
      crc = crc8_next(crc, b);
      send_byte(b, start && (i == 0), quiet);
    end
    send_byte(good ? crc : crc ^ 8'($urandom_range(1, 255)), 1'b0, quiet);
    aligned = 1'b1;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (readings_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_resolution(input logic [3:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // result side: random stall per transfer, two long hold-offs to back up the input
  initial begin
    int unsigned hold;
    int unsigned taken;
    out_stall = 1'b0;
    taken     = 0;
    wait (rst_n);
    forever begin
      hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
      if (taken == 15 || taken == 45) begin
        hold = 150;
      end
      if (hold > 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        do @(posedge clk); while (!out_valid);
        repeat (hold - 1) @(posedge clk);
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    logic [3:0]  res_plan[8];
    int          phase_end;
    int unsigned pick;
    int unsigned noise_len;
    logic        quiet;
    logic [7:0]  lo;
    logic [7:0]  hi;
    res_plan   = '{4'd9, 4'd0, 4'd15, 4'd10, 4'd13, 4'd11, 4'd8, 4'd12};
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    bytes_sent = 0;
    aligned    = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extreme temperatures, restart mid-frame, frame without start flag and with bad CRC
    send_frame(8'hFF, 8'h7F, 1'b1, 1'b1, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_frame(8'h00, 8'h80, 1'b1, 1'b1, 1'b1);
    send_frame(8'hF8, 8'hFF, 1'b0, 1'b0, 1'b0);
    drain();

    foreach (res_plan[p]) begin
      write_resolution(res_plan[p]);
      phase_end = bytes_sent + 112;
      while (bytes_sent < phase_end) begin
        pick  = $urandom_range(0, 19);
        quiet = ($urandom_range(0, 3) == 0);
        lo    = 8'($urandom_range(0, 255));
        hi    = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0) begin
          lo = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          hi = (lo == 8'hFF) ? 8'h7F : 8'h80;
        end
        if (pick < 14) begin
          send_frame(lo, hi, aligned ? 1'($urandom_range(0, 1)) : 1'b1, 1'b1, quiet);
        end else if (pick < 17) begin
          send_frame(lo, hi, aligned ? 1'($urandom_range(0, 1)) : 1'b1, 1'b0, quiet);
        end else begin
          noise_len = $urandom_range(1, 12);
          repeat (noise_len) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, quiet);
          end
          aligned = 1'b0;
        end
      end
      drain();
    end

    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: scratchpad_temperature_check_unit.f
+incdir+rtl
rtl/stc_pkg.sv
rtl/stc_frame.sv
rtl/stc_outbuf.sv
rtl/scratchpad_temperature_check_unit.sv
verif/temp_frame_check.sv
verif/tb.sv
